FILE: hw/rtl/asps_pkg.sv
// Package with the shared types and constants of the aligned pattern search.
package asps_pkg;

    localparam int PATTERN_MAX   = 16;
    localparam int BUFFER_MAX    = 65536;
    localparam int LEN_W         = 5;
    localparam int ALIGN_W       = 13;
    localparam int PHASE_W       = 12;
    localparam int COUNT_W       = 17;
    localparam int OFFSET_W      = 16;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int WIN_IDX_W     = $clog2(PATTERN_MAX);
    localparam int ALIGN_MAX     = 4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_ALIGNMENT      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] match_offset;
        logic                too_long;
    } out_item_t;

endpackage

FILE: hw/rtl/asps_if.sv
// Stream interfaces for the input bytes and the search results.
interface asps_in_if;
    logic              valid;
    logic              ready;
    asps_pkg::in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface asps_out_if;
    logic               valid;
    logic               ready;
    asps_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: hw/rtl/aligned_pattern_search.sv
// Top level of the aligned byte pattern search.
//
//   channel  direction  payload                          handshake
//   in_ch    sink       data_byte[7:0], last             valid / ready
//   out_ch   source     found, match_offset[15:0], ...   valid / ready
//   cfg      write      cfg_we, cfg_index[1:0], cfg_data[63:0]
//
// One byte is taken per cycle while in_ch.ready is high; the window shift
// and the compare of all pattern lengths finish in the cycle the byte is
// accepted. A buffer's result enters the queue as its last byte is accepted.
// Results wait in a two-entry queue, so bytes keep flowing while one result
// is stalled; in_ch.ready drops only when both entries are full.
// Reset clears the window, the counters and the queue, and loads the
// register reset values (pattern length 1, alignment 1).
module aligned_pattern_search (
    input  logic                                clk,
    input  logic                                rst_n,
    asps_in_if.sink                             in_ch,
    asps_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [asps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [asps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int PM = asps_pkg::PATTERN_MAX;

    // Configuration registers.
    logic [63:0]                     pattern_low_reg;
    logic [63:0]                     pattern_high_reg;
    logic [asps_pkg::LEN_W-1:0]      pattern_length_reg;
    logic [asps_pkg::ALIGN_W-1:0]    alignment_reg;

    // Search state.
    logic [7:0]                      window_reg [PM];
    logic [PM-1:0]                   marks_reg;
    logic [asps_pkg::COUNT_W-1:0]    byte_count_reg;
    logic [asps_pkg::PHASE_W-1:0]    phase_reg;
    logic                            match_seen_reg;
    logic [asps_pkg::OFFSET_W-1:0]   first_offset_reg;

    // Result queue.
    logic                            q0_valid_reg;
    logic                            q1_valid_reg;
    asps_pkg::out_item_t             q0_reg;
    asps_pkg::out_item_t             q1_reg;

    logic [7:0]                      window_next [PM];
    logic [PM-1:0]                   marks_next;
    logic [asps_pkg::COUNT_W-1:0]    byte_count_next;
    logic [asps_pkg::PHASE_W-1:0]    phase_next;
    logic                            match_seen_next;
    logic [asps_pkg::OFFSET_W-1:0]   first_offset_next;

    logic                            accept;
    logic                            pop;
    logic                            push;
    logic                            counting;
    logic [asps_pkg::LEN_W-1:0]      eff_len;
    logic [asps_pkg::WIN_IDX_W-1:0]  len_idx;
    logic [asps_pkg::ALIGN_W-1:0]    eff_align;
    logic [asps_pkg::ALIGN_W-1:0]    phase_inc;
    logic [asps_pkg::COUNT_W-1:0]    count_inc;
    logic [127:0]                    pattern_bits;
    logic [PM-1:0]                   len_match;
    logic                            hit;
    asps_pkg::out_item_t             result;

    assign accept       = in_ch.valid && in_ch.ready;
    assign pop          = q0_valid_reg && out_ch.ready;
    assign push         = accept && in_ch.item.last;
    assign in_ch.ready  = !q1_valid_reg;
    assign out_ch.valid = q0_valid_reg;
    assign out_ch.item  = q0_reg;

    assign pattern_bits = {pattern_high_reg, pattern_low_reg};
    assign counting     = (byte_count_reg < asps_pkg::COUNT_W'(asps_pkg::BUFFER_MAX));
    assign count_inc    = byte_count_reg + asps_pkg::COUNT_W'(1);
    assign phase_inc    = {1'b0, phase_reg} + asps_pkg::ALIGN_W'(1);

    always_comb
    begin
        if (pattern_length_reg == '0)
            eff_len = asps_pkg::LEN_W'(1);
        else if (pattern_length_reg > asps_pkg::LEN_W'(PM))
            eff_len = asps_pkg::LEN_W'(PM);
        else
            eff_len = pattern_length_reg;

        if (alignment_reg == '0)
            eff_align = asps_pkg::ALIGN_W'(1);
        else if (alignment_reg > asps_pkg::ALIGN_W'(asps_pkg::ALIGN_MAX))
            eff_align = asps_pkg::ALIGN_W'(asps_pkg::ALIGN_MAX);
        else
            eff_align = alignment_reg;
    end

    assign len_idx = asps_pkg::WIN_IDX_W'(eff_len - asps_pkg::LEN_W'(1));

    // The window after this byte is shifted in; index 0 holds the newest byte.
    always_comb
    begin
        window_next[0] = in_ch.item.data_byte;
        marks_next[0]  = (phase_reg == '0);
        for (int i = 1; i < PM; i++)
        begin
            window_next[i] = window_reg[i-1];
            marks_next[i]  = marks_reg[i-1];
        end
    end

    // For each candidate length L+1, the oldest byte at window index L must
    // equal pattern byte 0, and so on down to the newest byte.
    always_comb
    begin
        for (int l = 0; l < PM; l++)
        begin
            len_match[l] = 1'b1;
            for (int k = 0; k <= l; k++)
            begin
                if (window_next[l-k] != pattern_bits[8*k +: 8])
                    len_match[l] = 1'b0;
            end
        end
    end

    assign hit = len_match[len_idx] && marks_next[len_idx]
                 && (count_inc >= asps_pkg::COUNT_W'(eff_len));

    always_comb
    begin
        byte_count_next   = byte_count_reg;
        phase_next        = phase_reg;
        match_seen_next   = match_seen_reg;
        first_offset_next = first_offset_reg;
        if (counting)
        begin
            byte_count_next = count_inc;
            if (phase_inc >= eff_align)
                phase_next = '0;
            else
                phase_next = phase_inc[asps_pkg::PHASE_W-1:0];
            if (!match_seen_reg && hit)
            begin
                match_seen_next   = 1'b1;
                first_offset_next = asps_pkg::OFFSET_W'(count_inc
                                    - asps_pkg::COUNT_W'(eff_len));
            end
        end
        else
        begin
            byte_count_next = asps_pkg::COUNT_W'(asps_pkg::BUFFER_MAX + 1);
        end
    end

    always_comb
    begin
        result.found        = match_seen_next;
        result.match_offset = match_seen_next ? first_offset_next : '0;
        result.too_long     = (byte_count_next > asps_pkg::COUNT_W'(asps_pkg::BUFFER_MAX));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= asps_pkg::LEN_W'(1);
            alignment_reg      <= asps_pkg::ALIGN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (asps_pkg::cfg_index_t'(cfg_index))
                asps_pkg::CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                asps_pkg::CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                asps_pkg::CFG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg_data[asps_pkg::LEN_W-1:0];
                asps_pkg::CFG_ALIGNMENT:
                    alignment_reg <= cfg_data[asps_pkg::ALIGN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PM; i++)
                window_reg[i] <= '0;
            marks_reg        <= '0;
            byte_count_reg   <= '0;
            phase_reg        <= '0;
            match_seen_reg   <= 1'b0;
            first_offset_reg <= '0;
        end
        else if (accept)
        begin
            // The last byte of a buffer starts the next one from a clean state.
            if (in_ch.item.last)
            begin
                for (int i = 0; i < PM; i++)
                    window_reg[i] <= '0;
                marks_reg        <= '0;
                byte_count_reg   <= '0;
                phase_reg        <= '0;
                match_seen_reg   <= 1'b0;
                first_offset_reg <= '0;
            end
            else
            begin
                if (counting)
                begin
                    for (int i = 0; i < PM; i++)
                        window_reg[i] <= window_next[i];
                    marks_reg <= marks_next;
                end
                byte_count_reg   <= byte_count_next;
                phase_reg        <= phase_next;
                match_seen_reg   <= match_seen_next;
                first_offset_reg <= first_offset_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q0_valid_reg <= 1'b0;
            q1_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (q1_valid_reg)
                begin
                    q0_reg       <= q1_reg;
                    q1_valid_reg <= push;
                    if (push)
                        q1_reg <= result;
                end
                else
                begin
                    q0_valid_reg <= push;
                    if (push)
                        q0_reg <= result;
                end
            end
            else if (push)
            begin
                if (!q0_valid_reg)
                begin
                    q0_valid_reg <= 1'b1;
                    q0_reg       <= result;
                end
                else
                begin
                    q1_valid_reg <= 1'b1;
                    q1_reg       <= result;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/asps_checker.sv
// Port-level checks of the aligned pattern search and their binding.
module asps_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          in_last,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_found,
    input logic [asps_pkg::OFFSET_W-1:0] out_match_offset
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A result shows up only after a last byte was accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
        else $error("result without a last byte");

    // Input is held back only while results are queued.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with an empty result queue");

    // Without a match the offset reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_found |-> out_match_offset == '0)
        else $error("nonzero offset without a match");

endmodule

bind aligned_pattern_search asps_checker u_asps_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_last          (in_ch.item.last),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_found        (out_ch.item.found),
    .out_match_offset (out_ch.item.match_offset)
);
